/* hw/rtl/cau_pkg.sv */
// Shared types, widths and helpers for the complex arithmetic unit.
// Used by cau_qdiv and complex_arithmetic_unit_top; depends on nothing.
package cau_pkg;

  // Fraction bits of the Q format
  localparam int FRAC_BITS = 16;
  // Width of one operand or result part
  localparam int DW        = 32;
  // Width of a full product
  localparam int PW        = 2 * DW;
  // Signed working width for sums and the pre-saturation value
  localparam int WW        = PW + 2;
  // Quotient bits produced by the divider chain
  localparam int QBITS     = DW;
  // Shifted numerator, its upper part and the compare width
  localparam int XW        = PW + 2 * FRAC_BITS + QBITS;
  localparam int HW        = XW - QBITS;
  // Edges from an accepted item to the edge that takes its result
  localparam int LAT       = QBITS + 4;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_RECIP = 3'd4,
    OP_HERM  = 3'd5,
    OP_CONJ  = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_OVF = 2'd2
  } st_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic signed [DW-1:0]  a_re;
    logic signed [DW-1:0]  a_im;
    logic signed [DW-1:0]  b_re;
    logic signed [DW-1:0]  b_im;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0]  res_re;
    logic signed [DW-1:0]  res_im;
    logic [1:0]            status;
  } rsp_t;

  // Side data that rides along the divider chain
  typedef struct packed {
    logic                  is_div;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic                  big_re;
    logic                  big_im;
    logic signed [WW-1:0]  re;
    logic signed [WW-1:0]  im;
  } tag_t;

  // Working state of the two restoring divisions (shared divisor)
  typedef struct packed {
    logic [PW-1:0]     d;
    logic [PW-1:0]     rem_re;
    logic [PW-1:0]     rem_im;
    logic [QBITS-1:0]  low_re;
    logic [QBITS-1:0]  low_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
  } lane_t;

  typedef struct packed {
    logic           ovf;
    logic [DW-1:0]  val;
  } sat_t;

  // Clamp a wide signed value to DW bits
  function automatic sat_t sat32(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] smax;
    logic signed [WW-1:0] smin;
    sat_t r;
    smax = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    smin = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    r.ovf = (v > smax) || (v < smin);
    if (v > smax) begin
      r.val = smax[DW-1:0];
    end else if (v < smin) begin
      r.val = smin[DW-1:0];
    end else begin
      r.val = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cau_qdiv.sv */
// Pipelined restoring divider: one quotient bit per stage for two numerators
// over a shared divisor, with side data carried along. Depends on cau_pkg.
module cau_qdiv (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  cau_pkg::lane_t  in_lane,
  input  cau_pkg::tag_t   in_tag,
  output logic            out_valid,
  output cau_pkg::lane_t  out_lane,
  output cau_pkg::tag_t   out_tag
);

  logic [cau_pkg::QBITS:0] vld;
  cau_pkg::lane_t          lane [0:cau_pkg::QBITS];
  cau_pkg::tag_t           tag  [0:cau_pkg::QBITS];

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lane[0] <= in_lane;
    tag[0]  <= in_tag;
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= cau_pkg::QBITS; k++) begin : g_stage
    logic [cau_pkg::PW:0] r2_re;
    logic [cau_pkg::PW:0] r2_im;
    logic                 ge_re;
    logic                 ge_im;
    cau_pkg::lane_t       nxt;

    always_comb begin
      r2_re = {lane[k-1].rem_re, lane[k-1].low_re[cau_pkg::QBITS-1]};
      r2_im = {lane[k-1].rem_im, lane[k-1].low_im[cau_pkg::QBITS-1]};
      ge_re = r2_re >= {1'b0, lane[k-1].d};
      ge_im = r2_im >= {1'b0, lane[k-1].d};
      nxt        = lane[k-1];
      nxt.rem_re = ge_re ? cau_pkg::PW'(r2_re - {1'b0, lane[k-1].d})
                         : r2_re[cau_pkg::PW-1:0];
      nxt.rem_im = ge_im ? cau_pkg::PW'(r2_im - {1'b0, lane[k-1].d})
                         : r2_im[cau_pkg::PW-1:0];
      nxt.low_re = {lane[k-1].low_re[cau_pkg::QBITS-2:0], 1'b0};
      nxt.low_im = {lane[k-1].low_im[cau_pkg::QBITS-2:0], 1'b0};
      nxt.q_re   = {lane[k-1].q_re[cau_pkg::QBITS-2:0], ge_re};
      nxt.q_im   = {lane[k-1].q_im[cau_pkg::QBITS-2:0], ge_im};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      lane[k] <= nxt;
      tag[k]  <= tag[k-1];
    end
  end

  assign out_valid = vld[cau_pkg::QBITS];
  assign out_lane  = lane[cau_pkg::QBITS];
  assign out_tag   = tag[cau_pkg::QBITS];

endmodule

/* hw/rtl/complex_arithmetic_unit_top.sv */
// Complex arithmetic unit top level: multiplier, sum and divider-prep stages,
// the divider chain and the saturating output stage. Depends on cau_pkg, cau_qdiv.
//
// Fully pipelined: one item is taken on every cycle in which start is high
// and busy is low, and each item's result appears with done after it has
// passed one multiplier stage, one sum stage, one divider-prep stage,
// 32 divider stages of one quotient bit each and one output stage. Every
// opcode takes the same path, so results leave in order. busy is high only
// during reset. There is no output back-pressure: the result is valid for
// the single cycle that done is high.
module complex_arithmetic_unit_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cau_pkg::req_t  req,
  output logic           done,
  output cau_pkg::rsp_t  rsp
);

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------- stage 1: products ----------------
  cau_pkg::op_t                 in_op;
  logic signed [cau_pkg::DW-1:0] x_re;
  logic signed [cau_pkg::DW-1:0] x_im;

  assign in_op = cau_pkg::op_t'(req.req_type);
  // divisor squares come from a for the reciprocal, from b otherwise
  assign x_re  = (in_op == cau_pkg::OP_RECIP) ? req.a_re : req.b_re;
  assign x_im  = (in_op == cau_pkg::OP_RECIP) ? req.a_im : req.b_im;

  logic                          v1;
  cau_pkg::op_t                  op1;
  logic signed [cau_pkg::DW-1:0] ar1, ai1, br1, bi1;
  logic signed [cau_pkg::PW-1:0] p_rr, p_ii, p_ir, p_ri, sq_re, sq_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    op1   <= in_op;
    ar1   <= req.a_re;
    ai1   <= req.a_im;
    br1   <= req.b_re;
    bi1   <= req.b_im;
    p_rr  <= req.a_re * req.b_re;
    p_ii  <= req.a_im * req.b_im;
    p_ir  <= req.a_im * req.b_re;
    p_ri  <= req.a_re * req.b_im;
    sq_re <= x_re * x_re;
    sq_im <= x_im * x_im;
  end

  // ---------------- stage 2: sums, numerators, divisor ----------------
  logic signed [cau_pkg::WW-1:0] re_next, im_next;
  logic [cau_pkg::PW-1:0]        d_next;

  always_comb begin
    re_next = '0;
    im_next = '0;
    d_next  = $unsigned(sq_re) + $unsigned(sq_im);
    case (op1)
      cau_pkg::OP_ADD: begin
        re_next = cau_pkg::WW'(ar1) + cau_pkg::WW'(br1);
        im_next = cau_pkg::WW'(ai1) + cau_pkg::WW'(bi1);
      end
      cau_pkg::OP_SUB: begin
        re_next = cau_pkg::WW'(ar1) - cau_pkg::WW'(br1);
        im_next = cau_pkg::WW'(ai1) - cau_pkg::WW'(bi1);
      end
      cau_pkg::OP_MUL: begin
        re_next = (cau_pkg::WW'(p_rr) - cau_pkg::WW'(p_ii)) >>> cau_pkg::FRAC_BITS;
        im_next = (cau_pkg::WW'(p_ir) + cau_pkg::WW'(p_ri)) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::OP_HERM: begin
        re_next = (cau_pkg::WW'(p_rr) + cau_pkg::WW'(p_ii)) >>> cau_pkg::FRAC_BITS;
        im_next = (cau_pkg::WW'(p_ir) - cau_pkg::WW'(p_ri)) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::OP_DIV: begin
        // numerator a * conj(b)
        re_next = cau_pkg::WW'(p_rr) + cau_pkg::WW'(p_ii);
        im_next = cau_pkg::WW'(p_ir) - cau_pkg::WW'(p_ri);
      end
      cau_pkg::OP_RECIP, cau_pkg::OP_CONJ: begin
        re_next = cau_pkg::WW'(ar1);
        im_next = -cau_pkg::WW'(ai1);
      end
      default: begin
        re_next = '0;
        im_next = '0;
      end
    endcase
  end

  logic                          v2;
  cau_pkg::op_t                  op2;
  logic signed [cau_pkg::WW-1:0] re2, im2;
  logic [cau_pkg::PW-1:0]        d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op2 <= op1;
    re2 <= re_next;
    im2 <= im_next;
    d2  <= d_next;
  end

  // ---------------- stage 3: divider prep ----------------
  logic                          is_recip;
  logic signed [cau_pkg::WW-1:0] abs_re, abs_im;
  logic [cau_pkg::XW-1:0]        x_num_re, x_num_im;
  logic [cau_pkg::HW-1:0]        hi_re, hi_im;
  cau_pkg::lane_t                lane_in;
  cau_pkg::tag_t                 tag_in;

  assign is_recip = (op2 == cau_pkg::OP_RECIP);

  always_comb begin
    abs_re   = re2[cau_pkg::WW-1] ? -re2 : re2;
    abs_im   = im2[cau_pkg::WW-1] ? -im2 : im2;
    // numerator magnitude scaled by 2^F (divide) or 2^2F (reciprocal)
    x_num_re = is_recip
             ? (cau_pkg::XW'(abs_re[cau_pkg::PW-1:0]) << (2 * cau_pkg::FRAC_BITS))
             : (cau_pkg::XW'(abs_re[cau_pkg::PW-1:0]) << cau_pkg::FRAC_BITS);
    x_num_im = is_recip
             ? (cau_pkg::XW'(abs_im[cau_pkg::PW-1:0]) << (2 * cau_pkg::FRAC_BITS))
             : (cau_pkg::XW'(abs_im[cau_pkg::PW-1:0]) << cau_pkg::FRAC_BITS);
    hi_re    = x_num_re[cau_pkg::XW-1:cau_pkg::QBITS];
    hi_im    = x_num_im[cau_pkg::XW-1:cau_pkg::QBITS];

    lane_in.d      = d2;
    lane_in.rem_re = hi_re[cau_pkg::PW-1:0];
    lane_in.rem_im = hi_im[cau_pkg::PW-1:0];
    lane_in.low_re = x_num_re[cau_pkg::QBITS-1:0];
    lane_in.low_im = x_num_im[cau_pkg::QBITS-1:0];
    lane_in.q_re   = '0;
    lane_in.q_im   = '0;

    tag_in.is_div  = (op2 == cau_pkg::OP_DIV) || is_recip;
    tag_in.dz      = (d2 == '0);
    tag_in.neg_re  = re2[cau_pkg::WW-1];
    tag_in.neg_im  = im2[cau_pkg::WW-1];
    // quotient at or above 2^32 when the upper part already reaches d
    tag_in.big_re  = hi_re >= cau_pkg::HW'(d2);
    tag_in.big_im  = hi_im >= cau_pkg::HW'(d2);
    tag_in.re      = re2;
    tag_in.im      = im2;
  end

  // ---------------- divider chain ----------------
  logic           vq;
  cau_pkg::lane_t lane_q;
  cau_pkg::tag_t  tag_q;

  cau_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_lane   (lane_in),
    .in_tag    (tag_in),
    .out_valid (vq),
    .out_lane  (lane_q),
    .out_tag   (tag_q)
  );

  // ---------------- output: select and saturate ----------------
  logic signed [cau_pkg::WW-1:0] big_val;
  logic signed [cau_pkg::WW-1:0] qw_re, qw_im, fin_re, fin_im;
  cau_pkg::sat_t                 sat_re, sat_im;
  cau_pkg::rsp_t                 rsp_next;

  assign big_val = cau_pkg::WW'(1) <<< (cau_pkg::QBITS + 1);

  always_comb begin
    qw_re = tag_q.big_re ? big_val : cau_pkg::WW'({1'b0, lane_q.q_re});
    qw_im = tag_q.big_im ? big_val : cau_pkg::WW'({1'b0, lane_q.q_im});
    if (tag_q.neg_re) begin
      qw_re = -qw_re;
    end
    if (tag_q.neg_im) begin
      qw_im = -qw_im;
    end
    fin_re = tag_q.is_div ? qw_re : tag_q.re;
    fin_im = tag_q.is_div ? qw_im : tag_q.im;
    sat_re = cau_pkg::sat32(fin_re);
    sat_im = cau_pkg::sat32(fin_im);
    if (tag_q.is_div && tag_q.dz) begin
      rsp_next.res_re = '0;
      rsp_next.res_im = '0;
      rsp_next.status = cau_pkg::ST_DZ;
    end else begin
      rsp_next.res_re = sat_re.val;
      rsp_next.res_im = sat_im.val;
      rsp_next.status = (sat_re.ovf || sat_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // ---------------- assertions ----------------
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, cau_pkg::LAT))
    else $error("result without an item accepted LAT cycles earlier");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == cau_pkg::ST_DZ) |-> (rsp.res_re == '0 && rsp.res_im == '0))
    else $error("divide-by-zero result is not zero");

  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == cau_pkg::ST_OVF) |->
      (rsp.res_re == 32'sh7FFFFFFF || rsp.res_re == 32'sh80000000 ||
       rsp.res_im == 32'sh7FFFFFFF || rsp.res_im == 32'sh80000000))
    else $error("overflow status without a clamped part");

endmodule
